// ===== rtl/sdtq_pkg.sv =====
// shared types and codes for the sorted delay timer queue
// depends on nothing; imported by sdtq_cell and sorted_delay_timer_queue_top
package sdtq_pkg;

    localparam int TICK_W   = 32;
    localparam int WAITER_W = 8;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_TICK = 3'd0;
    localparam logic [OP_W-1:0] OP_TIME = 3'd1;
    localparam logic [OP_W-1:0] OP_REL  = 3'd2;
    localparam logic [OP_W-1:0] OP_ABS  = 3'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PASSED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic [TICK_W-1:0]   deadline;
        logic [WAITER_W-1:0] waiter;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctl_t;

endpackage

// ===== rtl/sdtq_cell.sv =====
// one slot of the sorted waiter chain: holds an entry, shifts towards the head
// on a pop and away from it on an insert; depends on sdtq_pkg
module sdtq_cell (
    input  logic               clk,
    input  logic               valid,
    input  sdtq_pkg::cell_ctl_t ctl,
    input  sdtq_pkg::entry_t   new_entry,
    input  sdtq_pkg::entry_t   left_entry,
    input  sdtq_pkg::entry_t   right_entry,
    input  logic               ins_left,
    output logic               ins_here,
    output sdtq_pkg::entry_t   entry
);
    import sdtq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // this slot lies at or after the insertion point
    assign ins_here = !valid || (entry_reg.deadline > new_entry.deadline);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.pop)
        begin
            entry_next = right_entry;
        end
        else if (ctl.insert)
        begin
            if (ins_left)
            begin
                entry_next = left_entry;
            end
            else if (ins_here)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/sorted_delay_timer_queue_top.sv =====
// top level of the sorted delay timer queue: tick counter, control and result
// registers around a chain of sdtq_cell slots; depends on sdtq_pkg, sdtq_cell
//
// usage
//   an item (operation, requester, request_ticks) is taken at a rising edge
//   with start high and busy low. results leave one per cycle on
//   reply_target, reply_value, status and is_last, marked by result_valid
//   for exactly one cycle; the receiver cannot hold them off
// timing and throughput
//   every result appears in the cycle after the edge that caused it
//   time query, delay, rejected or invalid items: the next item may follow
//   at once; a successful delay gives no result at all
//   tick: a result for the tick itself, then one per waiter released; the
//   chain pops one waiter per cycle at its head and busy stays high meanwhile
//   insertion: every slot compares its deadline with the new one and the
//   slots behind the insertion point shift one place along
// reset
//   rst_n clears the tick count and the occupancy (empty queue) at once;
//   slot contents are not cleared, slots beyond the occupancy are never read
module sorted_delay_timer_queue_top #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sdtq_pkg::OP_W-1:0]      operation,
    input  logic [sdtq_pkg::WAITER_W-1:0]  requester,
    input  logic [sdtq_pkg::TICK_W-1:0]    request_ticks,
    output logic                           result_valid,
    output logic [sdtq_pkg::WAITER_W-1:0]  reply_target,
    output logic [sdtq_pkg::TICK_W-1:0]    reply_value,
    output logic [sdtq_pkg::STATUS_W-1:0]  status,
    output logic                           is_last
);
    import sdtq_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE    = 2'b01,
        ST_RELEASE = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [TICK_W-1:0]     count_reg, count_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;

    logic                  valid_reg, valid_next;
    logic [WAITER_W-1:0]   target_reg, target_next;
    logic [TICK_W-1:0]     value_reg, value_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  last_reg, last_next;

    // chain signals; index QUEUE_DEPTH is a spare right neighbour for the tail
    entry_t                slot [QUEUE_DEPTH+1];
    logic                  ins  [QUEUE_DEPTH];
    entry_t                new_entry;
    cell_ctl_t             ctl;

    logic                  accept;
    logic                  full;
    logic [TICK_W:0]       rel_sum;
    logic [TICK_W-1:0]     rel_deadline;
    logic [TICK_W-1:0]     count_inc;

    assign accept    = start && !busy;
    assign full      = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign busy      = (state_reg == ST_RELEASE);
    assign count_inc = count_reg + 1'b1;

    // relative deadline saturates at the top of the tick range
    assign rel_sum      = {1'b0, count_reg} + {1'b0, request_ticks};
    assign rel_deadline = rel_sum[TICK_W] ? '1 : rel_sum[TICK_W-1:0];

    assign slot[QUEUE_DEPTH] = slot[QUEUE_DEPTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_ins;
            if (gi == 0)
            begin : g_head
                assign left_e   = new_entry;
                assign left_ins = 1'b0;
            end
            else
            begin : g_body
                assign left_e   = slot[gi-1];
                assign left_ins = ins[gi-1];
            end
            sdtq_cell u_cell (
                .clk         (clk),
                .valid       (OCC_W'(gi) < occ_reg),
                .ctl         (ctl),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .right_entry (slot[gi+1]),
                .ins_left    (left_ins),
                .ins_here    (ins[gi]),
                .entry       (slot[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        occ_next     = occ_reg;
        valid_next   = 1'b0;
        target_next  = target_reg;
        value_next   = '0;
        status_next  = STATUS_OK;
        last_next    = 1'b1;
        ctl          = '0;
        new_entry.waiter   = requester;
        new_entry.deadline = (operation == OP_REL) ? rel_deadline : request_ticks;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    valid_next  = 1'b1;
                    target_next = requester;
                    case (operation)
                        OP_TICK:
                        begin
                            count_next = count_inc;
                            // release phase only if the head has already expired
                            if ((occ_reg != '0) && (slot[0].deadline <= count_inc))
                            begin
                                last_next  = 1'b0;
                                state_next = ST_RELEASE;
                            end
                        end
                        OP_TIME:
                        begin
                            value_next = count_reg;
                        end
                        OP_REL:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                valid_next = 1'b0;
                                ctl.insert = 1'b1;
                                occ_next   = occ_reg + 1'b1;
                            end
                        end
                        OP_ABS:
                        begin
                            if (count_reg >= request_ticks)
                            begin
                                status_next = STATUS_PASSED;
                            end
                            else if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                valid_next = 1'b0;
                                ctl.insert = 1'b1;
                                occ_next   = occ_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_INVALID;
                        end
                    endcase
                end
            end
            ST_RELEASE:
            begin
                // pop the head; the next slot decides whether more follow
                valid_next  = 1'b1;
                target_next = slot[0].waiter;
                ctl.pop     = 1'b1;
                occ_next    = occ_reg - 1'b1;
                if ((occ_reg > OCC_W'(1)) && (slot[1].deadline <= count_reg))
                begin
                    last_next = 1'b0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            occ_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            occ_reg   <= occ_next;
            valid_reg <= valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign result_valid = valid_reg;
    assign reply_target = target_reg;
    assign reply_value  = value_reg;
    assign status       = status_reg;
    assign is_last      = last_reg;

    // occupancy never passes the chain length
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // the release phase only runs with waiters in the chain
    a_release_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (occ_reg != '0))
        else $error("release with empty queue");

    // a result that is not the last one is followed by another next cycle
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !is_last) |=> result_valid)
        else $error("result burst ended without last mark");

    // a released waiter has reached its deadline
    a_head_expired: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (slot[0].deadline <= count_reg))
        else $error("waiter released before deadline");

endmodule
